### rtl/mbps_pkg.sv
package mbps_pkg;

  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_BYTES     = 16;
  localparam int HALF_BYTES    = 8;
  localparam int MASK_W        = 16;
  localparam int LEN_CFG_W     = 5;
  localparam int OUT_OFFSET_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_WILDCARD_MASK  = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic advance;
  } cell_ctrl_t;

endpackage

### rtl/masked_byte_pattern_search.sv
// Scans a region one byte per cycle (unless stalled) for a pattern of up to
// PATTERN_MAX bytes (the registers hold sixteen), where wildcard positions
// match any byte. The first match in a region yields one transaction with
// found=1 and the start offset; a region with no match yields found=0,
// offset 0, at its last byte. Bytes flow through a row of PATTERN_MAX cells
// that all compare in the same cycle, so a byte is taken every cycle unless
// a result is stalled; each result is registered, and input keeps flowing
// while the output register drains. The byte counter is OFFSET_BITS wide
// and saturates. Write configuration only between transactions.
module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [OUT_OFFSET_W-1:0] match_offset
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [MASK_W-1:0]     wildcard_mask;
  logic [LEN_CFG_W-1:0]  pattern_length;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic                   match_reported;
  logic [OFFSET_BITS-1:0] offset_calc;
  logic [OFFSET_BITS-1:0] offset_reg;

  logic [LEN_W-1:0]       len;
  logic [7:0]             pattern [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] wild;
  logic [7:0]             chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] cell_ok;
  logic                   accept;
  logic                   hit;
  logic                   miss_end;
  cell_ctrl_t             ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= LEN_CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_WILDCARD_MASK:  wildcard_mask  <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(pattern_length) > 32'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
    if (i < HALF_BYTES) begin : g_lo
      assign pattern[i] = pattern_low[8*i +: 8];
      assign wild[i]    = wildcard_mask[i];
    end else if (i < CFG_BYTES) begin : g_hi
      assign pattern[i] = pattern_high[8*(i-HALF_BYTES) +: 8];
      assign wild[i]    = wildcard_mask[i];
    end else begin : g_none
      assign pattern[i] = '0;
      assign wild[i]    = 1'b0;
    end
  end

  assign accept       = in_valid && in_ready;
  assign in_ready     = !out_valid || out_ready;
  assign ctrl.advance = accept;
  assign chain[0]     = data_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    mbps_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .POSITION    (k),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .byte_in  (chain[k]),
      .len      (len),
      .pattern  (pattern),
      .wild     (wild),
      .byte_out (chain[k+1]),
      .ok       (cell_ok[k])
    );
  end

  always_comb begin
    bytes_seen_next = (bytes_seen == COUNT_MAX) ? bytes_seen
                                                : bytes_seen + OFFSET_BITS'(1);
    offset_calc     = bytes_seen_next - OFFSET_BITS'(len);
    hit      = !match_reported && (&cell_ok) && (bytes_seen_next >= OFFSET_BITS'(len));
    miss_end = last_byte && !match_reported && !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          bytes_seen     <= '0;
          match_reported <= 1'b0;
        end else begin
          bytes_seen     <= bytes_seen_next;
          match_reported <= match_reported || hit;
        end
      end
      if (accept && (hit || miss_end)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (hit || miss_end)) begin
      found      <= hit;
      offset_reg <= hit ? offset_calc : '0;
    end
  end

  if (OFFSET_BITS >= OUT_OFFSET_W) begin : g_off_trunc
    assign match_offset = offset_reg[OUT_OFFSET_W-1:0];
  end else begin : g_off_ext
    assign match_offset = OUT_OFFSET_W'(offset_reg);
  end

endmodule

### rtl/mbps_cell.sv
module mbps_cell import mbps_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int POSITION    = 0,
  parameter int LEN_W       = 5,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [7:0]       byte_in,
  input  logic [LEN_W-1:0] len,
  input  logic [7:0]       pattern [PATTERN_MAX],
  input  logic [PATTERN_MAX-1:0] wild,
  output logic [7:0]       byte_out,
  output logic             ok
);

  logic [LEN_W-1:0] diff;
  logic [IDX_W-1:0] idx;
  logic             in_use;

  // this cell sees the byte that arrived POSITION steps before the current one
  always_comb begin
    diff   = len - LEN_W'(POSITION) - LEN_W'(1);
    idx    = diff[IDX_W-1:0];
    in_use = len > LEN_W'(POSITION);
    ok     = !in_use || wild[idx] || (byte_in == pattern[idx]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      byte_out <= byte_in;
    end
  end

endmodule

### rtl/mbps_checker.sv
module mbps_checker import mbps_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [7:0]              data_byte,
  input logic                    last_byte,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    found,
  input logic [OUT_OFFSET_W-1:0] match_offset
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_offset == '0)
    else $error("not-found result with nonzero offset");

  a_new_needs_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result without an accepted byte");

  a_miss_at_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found && !$past(out_valid && !out_ready)
      |-> $past(in_valid && in_ready && last_byte))
    else $error("not-found result before region end");

endmodule

bind masked_byte_pattern_search mbps_checker u_checker (.*);
